>>> hdl/srvm_pkg.sv
// Shared types, constants and opcodes for the stack machine execute block.
// Used by the controller, the datapath and the top level.
package srvm_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int CODE_DEPTH  = 512;
    localparam int SA_W = $clog2(STACK_DEPTH);      // stack address width
    localparam int SP_W = SA_W + 1;                 // pointer that can hold the depth
    localparam int PC_W = $clog2(CODE_DEPTH);

    localparam logic [4:0] OP_LIT = 5'd1;
    localparam logic [4:0] OP_RTN = 5'd2;
    localparam logic [4:0] OP_LOD = 5'd3;
    localparam logic [4:0] OP_STO = 5'd4;
    localparam logic [4:0] OP_CAL = 5'd5;
    localparam logic [4:0] OP_INC = 5'd6;
    localparam logic [4:0] OP_JMP = 5'd7;
    localparam logic [4:0] OP_JPC = 5'd8;
    localparam logic [4:0] OP_SYS = 5'd9;
    localparam logic [4:0] OP_NEG = 5'd10;
    localparam logic [4:0] OP_ADD = 5'd11;
    localparam logic [4:0] OP_SUB = 5'd12;
    localparam logic [4:0] OP_MUL = 5'd13;
    localparam logic [4:0] OP_DIV = 5'd14;
    localparam logic [4:0] OP_ODD = 5'd15;
    localparam logic [4:0] OP_MOD = 5'd16;
    localparam logic [4:0] OP_EQL = 5'd17;
    localparam logic [4:0] OP_NEQ = 5'd18;
    localparam logic [4:0] OP_LSS = 5'd19;
    localparam logic [4:0] OP_LEQ = 5'd20;
    localparam logic [4:0] OP_GTR = 5'd21;
    localparam logic [4:0] OP_GEQ = 5'd22;

    localparam logic [15:0] SYS_OUT  = 16'd1;
    localparam logic [15:0] SYS_IN   = 16'd2;
    localparam logic [15:0] SYS_HALT = 16'd3;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;       // latch the input beat, snapshot operands
        logic clr_step;   // one stack clearing write
        logic walk_init;  // start link walk at base pointer
        logic walk_req;   // issue a stack read at the walk address
        logic walk_take;  // take returned stack word as next link
        logic rd_req;     // issue data read (LOD, RTN words)
        logic div_start;
        logic exec;       // commit the instruction
    } srvm_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic clr_done;
        logic walk_left;  // links still to walk
        logic walk_bad;   // current walk address out of range
        logic needs_walk;
        logic needs_rd;
        logic needs_div;
        logic div_busy;
        logic halted;
    } srvm_stat_t;

endpackage

>>> hdl/srvm_divider.sv
// Iterative signed divider: one quotient bit per cycle, truncating.
// Stands alone; instantiated by the datapath.
module srvm_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [31:0] quotient,
    output logic [31:0] remainder
);
    logic [31:0] q_reg, q_next, d_reg, d_next;
    logic [31:0] r_reg, r_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        qneg_reg, qneg_next, rneg_reg, rneg_next;
    logic [32:0] trial;

    assign busy      = (cnt_reg != 6'd0);
    assign quotient  = qneg_reg ? (32'd0 - q_reg) : q_reg;
    assign remainder = rneg_reg ? (32'd0 - r_reg) : r_reg;
    assign trial     = {r_reg, q_reg[31]} - {1'b0, d_reg};

    // The partial remainder stays below the divisor magnitude, at most 2^31,
    // so 32 bits hold it and its top bit is clear before each shift.
    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        if (start)
        begin
            q_next = dividend[31] ? (32'd0 - dividend) : dividend;
            d_next = divisor[31] ? (32'd0 - divisor) : divisor;
            r_next = 32'd0;
            cnt_next = 6'd32;
            qneg_next = dividend[31] ^ divisor[31];
            rneg_next = dividend[31];
        end
        else if (busy)
        begin
            if (!trial[32])
            begin
                r_next = trial[31:0];
                q_next = {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[30:0], q_reg[31]};
                q_next = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 6'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
    end
endmodule

>>> hdl/srvm_datapath.sv
// Datapath: register file, stack memory, pointers, link walk and ALU.
// Depends on srvm_pkg and srvm_divider.
module srvm_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  srvm_pkg::srvm_cmd_t  cmd,
    output srvm_pkg::srvm_stat_t stat,
    input  logic [4:0]           op,
    input  logic [2:0]           reg_sel,
    input  logic [3:0]           level,
    input  logic [15:0]          operand_m,
    input  logic [31:0]          read_value,
    output logic [8:0]           next_pc,
    output logic [31:0]          out_value,
    output logic                 out_valid,
    output logic                 halted,
    output logic                 fault
);
    import srvm_pkg::*;

    logic [31:0] mem [STACK_DEPTH];
    logic [31:0] rdata_reg;
    logic [31:0] regs_reg [8];

    logic [4:0]  op_reg;
    logic [2:0]  r_reg;
    logic [3:0]  lv_reg;
    logic [15:0] m_reg;
    logic [31:0] rv_reg, a_reg, b_reg, rr_reg;
    logic [31:0] prod_reg;

    logic [SP_W-1:0] sp_reg, bp_reg;
    logic [PC_W-1:0] pc_reg;
    logic            halt_reg;
    logic [SA_W:0]   clr_reg;

    logic [31:0] walk_reg;
    logic [3:0]  left_reg;
    logic [31:0] w1_reg;  // word at bp-1 for RTN
    logic [1:0]  rdph_reg;

    logic [31:0] q, rem;
    logic        dbusy;

    // Memory port arbitration: one write or one read per cycle.
    logic            we;
    logic [SA_W-1:0] waddr, raddr;
    logic [31:0]     wdata;
    logic            re;

    logic            srcbad, is_alu;
    logic [PC_W-1:0] npc_seq;
    logic [31:0]     addr_calc;
    logic            f;
    logic [31:0]     res;
    logic            wr_reg_en;
    logic [PC_W-1:0] pc_next;
    logic [SP_W-1:0] sp_next, bp_next;
    logic            cal_start;
    logic [2:0]      cal_cnt_reg;
    logic [SP_W-1:0] cal_bp_reg;
    logic [PC_W-1:0] cal_ret_reg;

    srvm_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (a_reg),
        .divisor   (b_reg),
        .busy      (dbusy),
        .quotient  (q),
        .remainder (rem)
    );

    assign is_alu  = (op_reg >= OP_ADD) && (op_reg <= OP_GEQ) && (op_reg != OP_ODD);
    assign srcbad  = is_alu && ((lv_reg > 4'd7) || (m_reg > 16'd7));
    assign npc_seq = pc_reg + 1'b1;
    assign addr_calc = walk_reg - {16'd0, m_reg};

    assign stat.clr_done   = clr_reg[SA_W];
    assign stat.walk_left  = (left_reg != 4'd0);
    assign stat.walk_bad   = (walk_reg >= 32'(STACK_DEPTH));
    assign stat.needs_walk = !srcbad && (op_reg == OP_LOD || op_reg == OP_STO
                              || op_reg == OP_CAL);
    assign stat.needs_rd   = !srcbad && (op_reg == OP_LOD || op_reg == OP_RTN);
    assign stat.needs_div  = !srcbad && (op_reg == OP_DIV || op_reg == OP_MOD)
                              && (b_reg != 32'd0);
    assign stat.div_busy   = dbusy;
    assign stat.halted     = halt_reg;

    // Read address: link walk, LOD data, or RTN words (bp-1 then bp-2).
    always_comb
    begin
        re = cmd.walk_req || cmd.rd_req;
        raddr = walk_reg[SA_W-1:0];
        if (cmd.rd_req)
        begin
            if (op_reg == OP_LOD)
                raddr = addr_calc[SA_W-1:0];
            else if (rdph_reg == 2'd0)
                raddr = SA_W'(bp_reg - 1'b1);
            else
                raddr = SA_W'(bp_reg - 2'd2);
        end
    end

    // Execute: fault detection, the register result and the next pointers.
    always_comb
    begin
        f = 1'b0;
        res = 32'd0;
        wr_reg_en = 1'b0;
        pc_next = npc_seq;
        sp_next = sp_reg;
        bp_next = bp_reg;
        case (op_reg)
            OP_LIT: begin res = {16'd0, m_reg}; wr_reg_en = 1'b1; end
            OP_RTN: begin
                f = (bp_reg < SP_W'(2)) || (w1_reg >= 32'(STACK_DEPTH));
                pc_next = rdata_reg[PC_W-1:0];
                sp_next = bp_reg + 1'b1;
                bp_next = w1_reg[SP_W-1:0];
            end
            OP_LOD: begin
                f = stat.walk_bad || ({16'd0, m_reg} > walk_reg);
                res = rdata_reg;
                wr_reg_en = 1'b1;
            end
            OP_STO: f = stat.walk_bad || ({16'd0, m_reg} > walk_reg);
            OP_CAL: begin
                f = stat.walk_bad || (sp_reg < SP_W'(3));
                pc_next = m_reg[PC_W-1:0];
                bp_next = sp_reg - 1'b1;
            end
            OP_INC: begin
                f = ({16'd0, m_reg} > 32'(sp_reg));
                sp_next = sp_reg - SP_W'(m_reg);
            end
            OP_JMP: pc_next = m_reg[PC_W-1:0];
            OP_JPC: if (rr_reg == 32'd0) pc_next = m_reg[PC_W-1:0];
            OP_SYS: begin res = rv_reg; wr_reg_en = (m_reg == SYS_IN); end
            OP_NEG: begin res = 32'd0 - rr_reg; wr_reg_en = 1'b1; end
            OP_ADD: begin res = a_reg + b_reg; wr_reg_en = 1'b1; end
            OP_SUB: begin res = a_reg - b_reg; wr_reg_en = 1'b1; end
            OP_MUL: begin res = prod_reg; wr_reg_en = 1'b1; end
            OP_DIV: begin f = (b_reg == 32'd0); res = q; wr_reg_en = 1'b1; end
            OP_ODD: begin
                res = rr_reg[0] ? (rr_reg[31] ? 32'hFFFF_FFFF : 32'd1) : 32'd0;
                wr_reg_en = 1'b1;
            end
            OP_MOD: begin f = (b_reg == 32'd0); res = rem; wr_reg_en = 1'b1; end
            OP_EQL: begin res = {31'd0, a_reg == b_reg}; wr_reg_en = 1'b1; end
            OP_NEQ: begin res = {31'd0, a_reg != b_reg}; wr_reg_en = 1'b1; end
            OP_LSS: begin res = {31'd0, $signed(a_reg) < $signed(b_reg)};
                          wr_reg_en = 1'b1; end
            OP_LEQ: begin res = {31'd0, $signed(a_reg) <= $signed(b_reg)};
                          wr_reg_en = 1'b1; end
            OP_GTR: begin res = {31'd0, $signed(a_reg) > $signed(b_reg)};
                          wr_reg_en = 1'b1; end
            OP_GEQ: begin res = {31'd0, $signed(a_reg) >= $signed(b_reg)};
                          wr_reg_en = 1'b1; end
            default: ;
        endcase
        if (srcbad)
        begin
            f = 1'b1;
        end
    end

    assign cal_start = cmd.exec && !halt_reg && !f && (op_reg == OP_CAL);

    // Memory write: clearing sweep, STO, or the three CAL words over cycles.
    always_comb
    begin
        we = 1'b0;
        waddr = clr_reg[SA_W-1:0];
        wdata = 32'd0;
        if (cmd.clr_step)
        begin
            we = 1'b1;
        end
        else if (cal_cnt_reg != 3'd0)
        begin
            we = 1'b1;
            case (cal_cnt_reg)
                3'd3: begin waddr = SA_W'(sp_reg - 1'b1); wdata = walk_reg; end
                3'd2: begin waddr = SA_W'(sp_reg - 2'd2);
                            wdata = 32'(cal_bp_reg); end
                default: begin waddr = SA_W'(sp_reg - 2'd3);
                            wdata = 32'(cal_ret_reg); end
            endcase
        end
        else if (cmd.exec && !f && op_reg == OP_STO)
        begin
            we = 1'b1;
            waddr = addr_calc[SA_W-1:0];
            wdata = regs_reg[r_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                regs_reg[i] <= 32'd0;
            sp_reg <= SP_W'(STACK_DEPTH);
            bp_reg <= SP_W'(STACK_DEPTH - 1);
            pc_reg <= '0;
            halt_reg <= 1'b0;
            clr_reg <= '0;
            cal_cnt_reg <= 3'd0;
            rdph_reg <= 2'd0;
            out_valid <= 1'b0;
            fault <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
                clr_reg <= clr_reg + 1'b1;
            if (cmd.load)
                rdph_reg <= 2'd0;
            else if (cmd.rd_req)
                rdph_reg <= rdph_reg + 1'b1;
            // The three CAL frame words go out after the commit, counted down by cal_cnt_reg.
            if (cal_start)
                cal_cnt_reg <= 3'd3;
            else if (cal_cnt_reg != 3'd0)
                cal_cnt_reg <= cal_cnt_reg - 1'b1;
            if (cmd.exec)
            begin
                if (halt_reg)
                begin
                    out_valid <= 1'b0;
                    fault <= 1'b0;
                end
                else
                begin
                    pc_reg <= f ? npc_seq : pc_next;
                    fault <= f;
                    out_valid <= !f && op_reg == OP_SYS && m_reg == SYS_OUT;
                    if (!f)
                    begin
                        if (wr_reg_en)
                            regs_reg[r_reg] <= res;
                        sp_reg <= sp_next;
                        bp_reg <= bp_next;
                        if (op_reg == OP_SYS && m_reg == SYS_HALT)
                            halt_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // Operand capture and walk bookkeeping.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= op;
            r_reg <= reg_sel;
            lv_reg <= level;
            m_reg <= operand_m;
            rv_reg <= read_value;
            a_reg <= regs_reg[level[2:0]];
            b_reg <= regs_reg[operand_m[2:0]];
            rr_reg <= regs_reg[reg_sel];
        end
        prod_reg <= a_reg * b_reg;
        if (cmd.walk_init)
        begin
            walk_reg <= 32'(bp_reg);
            left_reg <= lv_reg;
        end
        else if (cmd.walk_take)
        begin
            walk_reg <= rdata_reg;
            left_reg <= left_reg - 1'b1;
        end
        if (cmd.rd_req && op_reg == OP_RTN && rdph_reg == 2'd1)
            w1_reg <= rdata_reg;
        if (cal_start)
        begin
            cal_bp_reg <= bp_reg;
            cal_ret_reg <= npc_seq;
        end
    end

    assign next_pc   = 9'(pc_reg);
    assign out_value = out_valid ? rr_reg : 32'd0;
    assign halted    = halt_reg;
endmodule

>>> hdl/srvm_ctrl.sv
// Controller state machine sequencing clear, fetch of operands, link walk,
// memory reads, divide and commit. Depends on srvm_pkg.
module srvm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    output srvm_pkg::srvm_cmd_t  cmd,
    input  srvm_pkg::srvm_stat_t stat
);
    import srvm_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DEC   = 4'd2;
    localparam logic [3:0] S_WREQ  = 4'd3;
    localparam logic [3:0] S_WTAKE = 4'd4;
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_RD2   = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_EXEC  = 4'd8;
    localparam logic [3:0] S_CAL   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_MUL   = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [2:0] wait_reg, wait_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        state_next = state_reg;
        wait_next = wait_reg;
        cmd = '0;
        case (state_reg)
            S_CLEAR: begin
                if (stat.clr_done)
                    state_next = S_IDLE;
                else
                    cmd.clr_step = 1'b1;
            end
            S_IDLE: begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                cmd.walk_init = 1'b1;
                if (stat.halted)
                    state_next = S_EXEC;
                else if (stat.needs_walk)
                    state_next = S_WREQ;
                else if (stat.needs_rd)
                    state_next = S_RD;
                else if (stat.needs_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next = S_DIV;
                end
                else
                    state_next = S_MUL;
            end
            S_MUL: state_next = S_EXEC;
            S_WREQ: begin
                if (stat.walk_left && !stat.walk_bad)
                begin
                    cmd.walk_req = 1'b1;
                    state_next = S_WTAKE;
                end
                else if (stat.needs_rd && !stat.walk_bad)
                    state_next = S_RD;
                else
                    state_next = S_EXEC;
            end
            S_WTAKE: begin
                cmd.walk_take = 1'b1;
                state_next = S_WREQ;
            end
            S_RD: begin
                cmd.rd_req = 1'b1;
                state_next = S_RD2;
            end
            S_RD2: begin
                // RTN needs two words; LOD one.
                if (wait_reg == 3'd0 && !stat.needs_walk)
                begin
                    cmd.rd_req = 1'b1;
                    wait_next = 3'd1;
                    state_next = S_RD2;
                end
                else
                begin
                    wait_next = 3'd0;
                    state_next = S_EXEC;
                end
            end
            S_DIV: begin
                if (!stat.div_busy)
                    state_next = S_EXEC;
            end
            S_EXEC: begin
                cmd.exec = 1'b1;
                state_next = S_CAL;
            end
            S_CAL: begin
                if (wait_reg == 3'd4)
                begin
                    wait_next = 3'd0;
                    state_next = S_OUT;
                end
                else
                    wait_next = wait_reg + 1'b1;
            end
            S_OUT: begin
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            wait_reg <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg <= wait_next;
        end
    end
endmodule

>>> hdl/stack_register_vm_execute.sv
// Execute unit of a small register/stack machine: one instruction beat in,
// one result beat out, one instruction at a time. After reset a clearing pass
// zeroes the stack memory before the first beat is taken. A plain instruction
// goes through decode, multiply settle, commit, a wait that covers the CAL
// frame writes, result and idle. STO and CAL also walk the static links, each
// link a read and a take through the one read port of the stack memory; LOD
// also walks the links, and LOD and RTN add their data reads. DIV and MOD with
// a nonzero divisor wait on a one-bit-per-cycle divider in place of the
// multiply settle. Once halted, each beat goes from decode straight to commit.
module stack_register_vm_execute (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [4:0]  op,
    input  logic [2:0]  reg_sel,
    input  logic [3:0]  level,
    input  logic [15:0] operand_m,
    input  logic [31:0] read_value,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [8:0]  next_pc,
    output logic [31:0] out_value,
    output logic        out_valid,
    output logic        halted,
    output logic        fault
);
    import srvm_pkg::*;

    srvm_cmd_t  cmd;
    srvm_stat_t stat;

    srvm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (res_valid),
        .out_stall (res_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    srvm_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .op         (op),
        .reg_sel    (reg_sel),
        .level      (level),
        .operand_m  (operand_m),
        .read_value (read_value),
        .next_pc    (next_pc),
        .out_value  (out_value),
        .out_valid  (out_valid),
        .halted     (halted),
        .fault      (fault)
    );

`ifndef NO_ASSERTIONS
    // No new beat is taken while a result waits.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> in_stall)
        else $error("input taken while result pending");
    // Once halted, the machine stays halted.
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted |=> halted)
        else $error("halt flag dropped");
    // A halted machine reports no fault.
    a_halt_nofault: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && $past(halted)) |-> !fault)
        else $error("fault while halted");
`endif
endmodule
